### design/packet_descriptor_fifo_with_stats_macros.svh
// Assertion macros used by the queue design file.
`ifndef PACKET_DESCRIPTOR_FIFO_WITH_STATS_MACROS_SVH
`define PACKET_DESCRIPTOR_FIFO_WITH_STATS_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold at every rising clock edge outside reset.
`define PDFS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");
// The expression must never be true outside reset.
`define PDFS_ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define PDFS_ASSERT(name, clk, rst_n, prop)
`define PDFS_ASSERT_NEVER(name, clk, rst_n, expr)
`endif

`endif

### design/pdfs_pkg.sv
package pdfs_pkg;

  localparam int unsigned DEPTH  = 16384;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned OCC_W  = 15;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] handle;
    logic [15:0] length;
    logic [63:0] arrival;
  } entry_t;

  // Access request from the queue control to the descriptor store.
  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    logic  rd_en;
    addr_t rd_addr_a;
    addr_t rd_addr_b;
  } mem_req_t;

  function automatic addr_t next_slot(addr_t i);
    return (i == addr_t'(DEPTH - 1)) ? '0 : i + addr_t'(1);
  endfunction

endpackage

### design/pdfs_if.sv
interface pdfs_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] handle;
  logic [15:0] length;
  logic [63:0] now_us;

  modport source (output valid, kind, handle, length, now_us, input ready);
  modport sink   (input valid, kind, handle, length, now_us, output ready);
endinterface

interface pdfs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] popped_handle;
  logic        head_valid;
  logic [31:0] head_handle;
  logic [14:0] occupancy;
  logic [31:0] bytes_queued;
  logic [31:0] bytes_forwarded;
  logic [31:0] packets_forwarded;
  logic [63:0] last_sojourn_us;

  modport source (output valid, status, popped_handle, head_valid, head_handle, occupancy,
                  bytes_queued, bytes_forwarded, packets_forwarded, last_sojourn_us,
                  input ready);
  modport sink   (input valid, status, popped_handle, head_valid, head_handle, occupancy,
                  bytes_queued, bytes_forwarded, packets_forwarded, last_sojourn_us,
                  output ready);
endinterface

### design/pdfs_store.sv
module pdfs_store (
  input  logic              clk_i,
  input  pdfs_pkg::mem_req_t req_i,
  input  pdfs_pkg::entry_t  wr_entry_i,
  output pdfs_pkg::entry_t  rd_entry_a_o,
  output logic [31:0]       rd_handle_b_o
);

  logic [31:0] handle_mem  [pdfs_pkg::DEPTH];
  logic [15:0] length_mem  [pdfs_pkg::DEPTH];
  logic [63:0] arrival_mem [pdfs_pkg::DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      handle_mem[req_i.wr_addr]  <= wr_entry_i.handle;
      length_mem[req_i.wr_addr]  <= wr_entry_i.length;
      arrival_mem[req_i.wr_addr] <= wr_entry_i.arrival;
    end
  end

  // Reads return the contents from before a write in the same cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_entry_a_o.handle  <= handle_mem[req_i.rd_addr_a];
      rd_entry_a_o.length  <= length_mem[req_i.rd_addr_a];
      rd_entry_a_o.arrival <= arrival_mem[req_i.rd_addr_a];
      rd_handle_b_o        <= handle_mem[req_i.rd_addr_b];
    end
  end

endmodule

### design/packet_descriptor_fifo_with_stats.sv
// Packet descriptor queue with byte and packet counters. One item (push or pop) is
// accepted per clock while in_i.ready is high; its result passes a pointer and
// memory-read stage and then a result register, and the queue keeps taking items while
// a result waits unless both stages are full and the output is stalled. The depth-16384
// descriptor store is a single-write, dual-read memory with registered reads; it needs
// no clearing pass, so items are accepted right after reset. Head, tail and count move
// at acceptance, while byte counts and sojourn time are settled in the second stage
// once the head entry has been read from the memory.
`include "packet_descriptor_fifo_with_stats_macros.svh"

module packet_descriptor_fifo_with_stats (
  input  logic       clk_i,
  input  logic       rst_ni,
  pdfs_in_if.sink    in_i,
  pdfs_out_if.source out_o
);

  pdfs_pkg::addr_t head_q, head_d, tail_q, tail_d, head_nxt;
  pdfs_pkg::cnt_t  count_q, count_d;

  logic accept, is_pop, push_ok, pop_ok, s1_advance;

  pdfs_pkg::mem_req_t mem_req;
  pdfs_pkg::entry_t   wr_entry, rd_entry_a;
  logic [31:0]        rd_handle_b;

  // First stage: item after pointer update, waiting for memory data.
  logic                s1_valid_q;
  pdfs_pkg::status_e   s1_status_q;
  logic                s1_push_ok_q, s1_pop_ok_q, s1_fwd_q;
  logic [31:0]         s1_handle_q;
  logic [15:0]         s1_length_q;
  logic [63:0]         s1_now_q;
  pdfs_pkg::cnt_t      s1_count_q;

  // Result stage and running counters.
  logic                out_valid_q;
  pdfs_pkg::status_e   out_status_q;
  logic [31:0]         out_popped_q, out_head_handle_q;
  logic                out_head_valid_q;
  logic [pdfs_pkg::OCC_W-1:0] out_occ_q;
  logic [31:0]         queued_q, queued_d, tbytes_q, tbytes_d, tpkts_q, tpkts_d;
  logic [63:0]         sojourn_q, sojourn_d;
  logic [64:0]         sojourn_diff;

  assign s1_advance  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_advance;
  assign accept      = in_i.valid && in_i.ready;

  assign is_pop   = (in_i.kind == pdfs_pkg::KIND_POP);
  assign push_ok  = !is_pop && (count_q != pdfs_pkg::cnt_t'(pdfs_pkg::DEPTH));
  assign pop_ok   = is_pop && (count_q != '0);
  assign head_nxt = pdfs_pkg::next_slot(head_q);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (accept && push_ok) begin
      tail_d  = pdfs_pkg::next_slot(tail_q);
      count_d = count_q + pdfs_pkg::cnt_t'(1);
    end else if (accept && pop_ok) begin
      head_d  = head_nxt;
      count_d = count_q - pdfs_pkg::cnt_t'(1);
    end
  end

  always_comb begin
    mem_req.wr_en     = accept && push_ok;
    mem_req.wr_addr   = tail_q;
    mem_req.rd_en     = accept;
    mem_req.rd_addr_a = head_q;
    mem_req.rd_addr_b = pop_ok ? head_nxt : head_q;
    wr_entry.handle   = in_i.handle;
    wr_entry.length   = in_i.length;
    wr_entry.arrival  = in_i.now_us;
  end

  pdfs_store u_store (
    .clk_i        (clk_i),
    .req_i        (mem_req),
    .wr_entry_i   (wr_entry),
    .rd_entry_a_o (rd_entry_a),
    .rd_handle_b_o(rd_handle_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!is_pop && !push_ok) begin
        s1_status_q <= pdfs_pkg::ST_FULL;
      end else if (is_pop && !pop_ok) begin
        s1_status_q <= pdfs_pkg::ST_EMPTY;
      end else begin
        s1_status_q <= pdfs_pkg::ST_DONE;
      end
      s1_push_ok_q <= push_ok;
      s1_pop_ok_q  <= pop_ok;
      // A push into an empty queue becomes the head in the same cycle the
      // memory is written, so the read would miss it.
      s1_fwd_q     <= push_ok && (count_q == '0);
      s1_handle_q  <= in_i.handle;
      s1_length_q  <= in_i.length;
      s1_now_q     <= in_i.now_us;
      s1_count_q   <= count_d;
    end
  end

  assign sojourn_diff = {1'b0, s1_now_q} - {1'b0, rd_entry_a.arrival};

  always_comb begin
    queued_d  = queued_q;
    tbytes_d  = tbytes_q;
    tpkts_d   = tpkts_q;
    sojourn_d = sojourn_q;
    if (s1_push_ok_q) begin
      queued_d = queued_q + 32'(s1_length_q);
      tbytes_d = tbytes_q + 32'(s1_length_q);
      tpkts_d  = tpkts_q + 32'd1;
    end else if (s1_pop_ok_q) begin
      queued_d  = queued_q - 32'(rd_entry_a.length);
      // A borrow out means the arrival lies in the future.
      sojourn_d = sojourn_diff[64] ? 64'd0 : sojourn_diff[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      queued_q    <= '0;
      tbytes_q    <= '0;
      tpkts_q     <= '0;
      sojourn_q   <= '0;
    end else begin
      if (s1_advance) begin
        out_valid_q <= 1'b1;
        queued_q    <= queued_d;
        tbytes_q    <= tbytes_d;
        tpkts_q     <= tpkts_d;
        sojourn_q   <= sojourn_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_status_q      <= s1_status_q;
      out_popped_q      <= s1_pop_ok_q ? rd_entry_a.handle : 32'd0;
      out_head_valid_q  <= (s1_count_q != '0);
      if (s1_count_q == '0) begin
        out_head_handle_q <= 32'd0;
      end else if (s1_fwd_q) begin
        out_head_handle_q <= s1_handle_q;
      end else begin
        out_head_handle_q <= rd_handle_b;
      end
      out_occ_q         <= pdfs_pkg::OCC_W'(s1_count_q);
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.status            = out_status_q;
  assign out_o.popped_handle     = out_popped_q;
  assign out_o.head_valid        = out_head_valid_q;
  assign out_o.head_handle       = out_head_handle_q;
  assign out_o.occupancy         = out_occ_q;
  assign out_o.bytes_queued      = queued_q;
  assign out_o.bytes_forwarded   = tbytes_q;
  assign out_o.packets_forwarded = tpkts_q;
  assign out_o.last_sojourn_us   = sojourn_q;

  `PDFS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= pdfs_pkg::cnt_t'(pdfs_pkg::DEPTH))
  `PDFS_ASSERT_NEVER(a_empty_ptrs, clk_i, rst_ni, count_q == '0 && head_q != tail_q)
  `PDFS_ASSERT(a_full_drop, clk_i, rst_ni, accept && !is_pop && !push_ok |=> s1_valid_q && s1_status_q == pdfs_pkg::ST_FULL && $stable(tail_q))
  `PDFS_ASSERT(a_stall_hold, clk_i, rst_ni, out_valid_q && !out_o.ready |=> $stable(queued_q) && $stable(sojourn_q))

endmodule

### tb/tb_packet_descriptor_fifo_with_stats.sv
module tb_packet_descriptor_fifo_with_stats;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned RAND_BLOCKS = 31;

  typedef struct {
    pdfs_pkg::kind_e kind;
    logic [31:0]     handle;
    logic [15:0]     length;
    logic [63:0]     now_us;
    int unsigned     idle_max;
  } fifo_op_t;

  typedef struct {
    pdfs_pkg::status_e status;
    logic [31:0]       popped_handle;
    logic              head_valid;
    logic [31:0]       head_handle;
    logic [14:0]       occupancy;
    logic [31:0]       bytes_queued;
    logic [31:0]       bytes_forwarded;
    logic [31:0]       packets_forwarded;
    logic [63:0]       last_sojourn_us;
  } fifo_result_t;

  typedef struct {
    fifo_result_t res;
    int unsigned  idle_max;
  } fifo_expect_t;

  logic clk_i;
  logic rst_ni;

  pdfs_in_if  in_if ();
  pdfs_out_if out_if ();

  packet_descriptor_fifo_with_stats dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Descriptor store and counters of the predicted queue.
  logic [31:0]     slot_handle  [pdfs_pkg::DEPTH];
  logic [15:0]     slot_length  [pdfs_pkg::DEPTH];
  logic [63:0]     slot_arrival [pdfs_pkg::DEPTH];
  pdfs_pkg::addr_t rd_ptr;
  pdfs_pkg::addr_t wr_ptr;
  pdfs_pkg::cnt_t  held;
  logic [31:0]     held_bytes;
  logic [31:0]     fwd_bytes;
  logic [31:0]     fwd_packets;
  logic [63:0]     sojourn;

  fifo_op_t     op_queue [$];
  fifo_expect_t result_queue [$];

  logic [63:0] clock_us;
  int unsigned gap_left;
  bit          gap_drawn;
  int unsigned stall_left;
  int unsigned fail_count;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic fifo_result_t fifo_apply(fifo_op_t op);
    fifo_result_t r;
    r.status        = pdfs_pkg::ST_DONE;
    r.popped_handle = '0;
    if (op.kind == pdfs_pkg::KIND_PUSH) begin
      if (held == pdfs_pkg::cnt_t'(pdfs_pkg::DEPTH)) begin
        r.status = pdfs_pkg::ST_FULL;
      end else begin
        slot_handle[wr_ptr]  = op.handle;
        slot_length[wr_ptr]  = op.length;
        slot_arrival[wr_ptr] = op.now_us;
        // DEPTH is a power of two, so the pointer wraps on its own.
        wr_ptr      = wr_ptr + 1'b1;
        held        = held + 1'b1;
        held_bytes  = held_bytes + 32'(op.length);
        fwd_bytes   = fwd_bytes + 32'(op.length);
        fwd_packets = fwd_packets + 32'd1;
      end
    end else begin
      if (held == '0) begin
        r.status = pdfs_pkg::ST_EMPTY;
      end else begin
        r.popped_handle = slot_handle[rd_ptr];
        held_bytes      = held_bytes - 32'(slot_length[rd_ptr]);
        sojourn         = (op.now_us >= slot_arrival[rd_ptr]) ?
                          op.now_us - slot_arrival[rd_ptr] : '0;
        rd_ptr          = rd_ptr + 1'b1;
        held            = held - 1'b1;
      end
    end
    r.head_valid        = (held != '0);
    r.head_handle       = (held != '0) ? slot_handle[rd_ptr] : '0;
    r.occupancy         = 15'(held);
    r.bytes_queued      = held_bytes;
    r.bytes_forwarded   = fwd_bytes;
    r.packets_forwarded = fwd_packets;
    r.last_sojourn_us   = sojourn;
    return r;
  endfunction

  task automatic add_op(pdfs_pkg::kind_e kind, logic [31:0] handle, logic [15:0] length,
                        logic [63:0] now_us, int unsigned idle_max);
    fifo_op_t op;
    op.kind     = kind;
    op.handle   = handle;
    op.length   = length;
    op.now_us   = now_us;
    op.idle_max = idle_max;
    op_queue.push_back(op);
  endtask

  // Mostly a rising clock, with now and then a value from anywhere so that
  // arrivals later than the pop time occur.
  function automatic logic [63:0] pick_now();
    int unsigned r;
    r = $urandom_range(0, 31);
    if (r == 0) return {$urandom, $urandom};
    if (r == 1) return '1;
    if (r == 2) return '0;
    clock_us = clock_us + 64'($urandom_range(0, 40));
    return clock_us;
  endfunction

  function automatic logic [15:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return 16'($urandom);
  endfunction

  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (act_val !== exp_val) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %s: expected %0h, got %0h", name, exp_val, act_val);
    end
  endtask

  // Driver: presents the oldest pending item after its drawn gap.
  always @(posedge clk_i) begin
    fifo_expect_t e;
    logic         nxt_valid;
    nxt_valid = 1'b0;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        e.idle_max = op_queue[0].idle_max;
        e.res      = fifo_apply(op_queue.pop_front());
        result_queue.push_back(e);
        gap_drawn = 1'b0;
      end
      if (in_if.valid && !in_if.ready) begin
        nxt_valid = 1'b1;
      end else if (op_queue.size() > 0) begin
        if (!gap_drawn) begin
          gap_left  = $urandom_range(op_queue[0].idle_max, 0);
          gap_drawn = 1'b1;
        end
        if (gap_left == 0) nxt_valid = 1'b1;
        else gap_left--;
      end
    end
    in_if.valid <= nxt_valid;
    if (nxt_valid) begin
      in_if.kind   <= op_queue[0].kind;
      in_if.handle <= op_queue[0].handle;
      in_if.length <= op_queue[0].length;
      in_if.now_us <= op_queue[0].now_us;
    end
  end

  // Monitor: checks each result item and stalls the output at random.
  always @(posedge clk_i) begin
    fifo_expect_t e;
    logic         nxt_ready;
    nxt_ready = out_if.ready;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (result_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result item with no pending expectation");
          stall_left = 0;
        end else begin
          e = result_queue.pop_front();
          check_field("status", 64'(e.res.status), 64'(out_if.status));
          check_field("popped_handle", 64'(e.res.popped_handle), 64'(out_if.popped_handle));
          check_field("head_valid", 64'(e.res.head_valid), 64'(out_if.head_valid));
          check_field("head_handle", 64'(e.res.head_handle), 64'(out_if.head_handle));
          check_field("occupancy", 64'(e.res.occupancy), 64'(out_if.occupancy));
          check_field("bytes_queued", 64'(e.res.bytes_queued), 64'(out_if.bytes_queued));
          check_field("bytes_forwarded", 64'(e.res.bytes_forwarded),
                      64'(out_if.bytes_forwarded));
          check_field("packets_forwarded", 64'(e.res.packets_forwarded),
                      64'(out_if.packets_forwarded));
          check_field("last_sojourn_us", e.res.last_sojourn_us, out_if.last_sojourn_us);
          stall_left = $urandom_range(e.idle_max, 0);
        end
        if (stall_left > 0) nxt_ready = 1'b0;
      end else if (!out_if.ready) begin
        if (stall_left > 0) stall_left--;
        if (stall_left == 0) nxt_ready = 1'b1;
      end
    end
    out_if.ready <= nxt_ready;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned push_pct;
    int unsigned bound;
    in_if.valid  = 1'b0;
    in_if.kind   = pdfs_pkg::KIND_PUSH;
    in_if.handle = '0;
    in_if.length = '0;
    in_if.now_us = '0;
    out_if.ready = 1'b0;
    rst_ni       = 1'b0;
    rd_ptr       = '0;
    wr_ptr       = '0;
    held         = '0;
    held_bytes   = '0;
    fwd_bytes    = '0;
    fwd_packets  = '0;
    sojourn      = '0;
    gap_left     = 0;
    gap_drawn    = 1'b0;
    stall_left   = 0;
    fail_count   = 0;
    quiet_cycles = 0;
    clock_us     = {32'h0, $urandom};

    // Directed items: empty pops, field extremes, sojourn at both ends and
    // saturated at zero.
    add_op(pdfs_pkg::KIND_POP, 32'hFFFF_FFFF, 16'hFFFF, 64'h0, 8);
    add_op(pdfs_pkg::KIND_PUSH, 32'h0, 16'h0, 64'h0, 8);
    add_op(pdfs_pkg::KIND_PUSH, 32'hFFFF_FFFF, 16'hFFFF, '1, 0);
    add_op(pdfs_pkg::KIND_PUSH, $urandom, 16'h1, 64'd5, 0);
    add_op(pdfs_pkg::KIND_POP, 32'h0, 16'h0, '1, 8);
    add_op(pdfs_pkg::KIND_POP, 32'h0, 16'h0, 64'h0, 0);
    add_op(pdfs_pkg::KIND_POP, 32'h0, 16'h0, 64'd5, 0);
    add_op(pdfs_pkg::KIND_POP, 32'h0, 16'h0, '1, 8);
    add_op(pdfs_pkg::KIND_PUSH, 32'hA5A5_A5A5, 16'h8000, 64'd100, 8);
    add_op(pdfs_pkg::KIND_PUSH, 32'h5A5A_5A5A, 16'h7FFF, 64'd50, 0);
    add_op(pdfs_pkg::KIND_POP, 32'h0, 16'h0, 64'd200, 0);
    add_op(pdfs_pkg::KIND_POP, 32'h0, 16'h0, 64'd40, 8);
    add_op(pdfs_pkg::KIND_PUSH, 32'h8000_0001, 16'hFFFF, 64'h8000_0000_0000_0000, 0);
    add_op(pdfs_pkg::KIND_POP, 32'h0, 16'h0, 64'h7FFF_FFFF_FFFF_FFFF, 0);
    add_op(pdfs_pkg::KIND_POP, 32'hFFFF_FFFF, 16'hFFFF, '1, 0);

    // Random items in blocks, each leaning toward pushes, pops or neither.
    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      case ($urandom_range(0, 2))
        0: push_pct = 25;
        1: push_pct = 50;
        default: push_pct = 75;
      endcase
      bound = ($urandom_range(0, 3) == 0) ? 0 : 8;
      for (int i = 0; i < 50; i++)
        add_op(($urandom_range(0, 99) < push_pct) ? pdfs_pkg::KIND_PUSH : pdfs_pkg::KIND_POP,
               $urandom, pick_length(), pick_now(), bound);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (op_queue.size() != 0 || result_queue.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (fail_count == 0 && result_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/pdfs_pkg.sv
design/pdfs_if.sv
design/pdfs_store.sv
design/packet_descriptor_fifo_with_stats.sv
tb/tb_packet_descriptor_fifo_with_stats.sv
